// ===== hw/rtl/msb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_pkg: shared definitions of the Morse status blinker
// Register indexes, reset values, element codes, pattern ROM and the
// configuration and status structs passed between the modules.
// ----------------------------------------------------------------------------
package msb_pkg;

   localparam int TIMER_BITS_DEF = 16;
   localparam int CODE_COUNT_DEF = 9;

   localparam int CODE_BITS    = 8;
   localparam int PATTERN_BITS = 6;
   localparam int ELEM_BITS    = 2;
   localparam int TICK_BITS    = 8;
   localparam int FRAME_BITS   = 16;
   localparam int CSR_IDX_BITS = 8;
   localparam int CSR_DAT_BITS = 16;
   localparam int ROM_DEPTH    = 16;

   localparam logic [CSR_IDX_BITS-1:0] REG_DOT   = 8'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_GAP   = 8'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_DASH  = 8'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_FRAME = 8'd3;

   localparam logic [TICK_BITS-1:0]  DOT_RESET   = 8'd45;
   localparam logic [TICK_BITS-1:0]  GAP_RESET   = 8'd60;
   localparam logic [TICK_BITS-1:0]  DASH_RESET  = 8'd150;
   localparam logic [FRAME_BITS-1:0] FRAME_RESET = FRAME_BITS'(2250 / 3);

   localparam logic [ELEM_BITS-1:0] ELEM_DOT  = 2'b10;
   localparam logic [ELEM_BITS-1:0] ELEM_DASH = 2'b11;

   typedef struct packed {
      logic [TICK_BITS-1:0]  dot_ticks;
      logic [TICK_BITS-1:0]  gap_ticks;
      logic [TICK_BITS-1:0]  dash_ticks;
      logic [FRAME_BITS-1:0] frame_ticks;
   } msb_cfg_type;

   typedef struct packed {
      logic lamp;
      logic elem_lit;
   } msb_stat_type;

   // first element in bits 1:0; dot = 2, dash = 3
   function automatic logic [PATTERN_BITS-1:0] code_rom(input logic [3:0] idx);
      logic [PATTERN_BITS-1:0] pat;
      case (idx)
         4'd0:    pat = 6'h2E;  // R
         4'd1:    pat = 6'h02;  // E
         4'd2:    pat = 6'h0E;  // A
         4'd3:    pat = 6'h0F;  // M
         4'd4:    pat = 6'h0B;  // N
         4'd5:    pat = 6'h0A;  // I
         4'd6:    pat = 6'h3A;  // U
         4'd7:    pat = 6'h3F;  // O
         4'd8:    pat = 6'h2A;  // S
         default: pat = '0;
      endcase
      return pat;
   endfunction

endpackage

// ===== hw/rtl/msb_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_regs: configuration registers
// Holds the element, gap and frame tick counts; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module msb_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [msb_pkg::CSR_IDX_BITS-1:0]    wr_index,
   input  logic [msb_pkg::CSR_DAT_BITS-1:0]    wr_data,
   output msb_pkg::msb_cfg_type                cfg
);
   import msb_pkg::*;

   msb_cfg_type cfg_ff;
   msb_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            REG_DOT:   cfg_in.dot_ticks   = wr_data[TICK_BITS-1:0];
            REG_GAP:   cfg_in.gap_ticks   = wr_data[TICK_BITS-1:0];
            REG_DASH:  cfg_in.dash_ticks  = wr_data[TICK_BITS-1:0];
            REG_FRAME: cfg_in.frame_ticks = wr_data[FRAME_BITS-1:0];
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dot_ticks   <= DOT_RESET;
         cfg_ff.gap_ticks   <= GAP_RESET;
         cfg_ff.dash_ticks  <= DASH_RESET;
         cfg_ff.frame_ticks <= FRAME_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/msb_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_core: blink sequencer state and per-poll update
// Frame step then flip step against the frame and flip due times, one poll
// per enabled cycle.
// ----------------------------------------------------------------------------
module msb_core #(
   parameter int TIMER_BITS = msb_pkg::TIMER_BITS_DEF,
   parameter int CODE_COUNT = msb_pkg::CODE_COUNT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  logic [TIMER_BITS-1:0]             now,
   input  logic [msb_pkg::CODE_BITS-1:0]     code,
   input  msb_pkg::msb_cfg_type              cfg,
   output logic                              led_next,
   output msb_pkg::msb_stat_type             stat
);
   import msb_pkg::*;

   localparam int EXT_BITS = (TIMER_BITS > FRAME_BITS) ? TIMER_BITS : FRAME_BITS;

   logic [TIMER_BITS-1:0]   frame_due_ff, frame_due_in;
   logic [TIMER_BITS-1:0]   flip_due_ff, flip_due_in;
   logic [PATTERN_BITS-1:0] pattern_ff, pattern_in;
   logic                    lamp_ff, lamp_in;

   logic [EXT_BITS-1:0]     frame_ext, gap_ext, dot_ext, dash_ext;
   logic [TIMER_BITS-1:0]   frame_add, gap_add, dot_add, dash_add;
   logic [TIMER_BITS-1:0]   flip_mid;
   logic [PATTERN_BITS-1:0] pattern_mid;
   logic                    lamp_mid;
   logic [ELEM_BITS-1:0]    elem;

   assign frame_ext = EXT_BITS'(cfg.frame_ticks);
   assign gap_ext   = EXT_BITS'(cfg.gap_ticks);
   assign dot_ext   = EXT_BITS'(cfg.dot_ticks);
   assign dash_ext  = EXT_BITS'(cfg.dash_ticks);

   assign frame_add = now + frame_ext[TIMER_BITS-1:0];
   assign gap_add   = now + gap_ext[TIMER_BITS-1:0];
   assign dot_add   = now + dot_ext[TIMER_BITS-1:0];
   assign dash_add  = now + dash_ext[TIMER_BITS-1:0];

   always_comb begin
      frame_due_in = frame_due_ff;
      flip_mid     = flip_due_ff;
      pattern_mid  = pattern_ff;
      lamp_mid     = lamp_ff;
      if (frame_due_ff == now) begin
         if (code < CODE_BITS'(CODE_COUNT)) begin
            flip_mid    = now;
            pattern_mid = code_rom(code[3:0]);
         end else begin
            pattern_mid = '0;
         end
         frame_due_in = frame_add;
         lamp_mid     = 1'b0;
      end

      elem        = pattern_mid[ELEM_BITS-1:0];
      flip_due_in = flip_mid;
      pattern_in  = pattern_mid;
      lamp_in     = lamp_mid;
      if (flip_mid == now) begin
         if (lamp_mid) begin
            flip_due_in = gap_add;
            pattern_in  = pattern_mid >> ELEM_BITS;
            lamp_in     = 1'b0;
         end else if (elem == ELEM_DOT) begin
            flip_due_in = dot_add;
            lamp_in     = 1'b1;
         end else if (elem == ELEM_DASH) begin
            flip_due_in = dash_add;
            lamp_in     = 1'b1;
         end else begin
            lamp_in     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_due_ff <= '0;
         flip_due_ff  <= '0;
         pattern_ff   <= '0;
         lamp_ff      <= 1'b0;
      end else if (step) begin
         frame_due_ff <= frame_due_in;
         flip_due_ff  <= flip_due_in;
         pattern_ff   <= pattern_in;
         lamp_ff      <= lamp_in;
      end
   end

   assign led_next      = lamp_in;
   assign stat.lamp     = lamp_ff;
   assign stat.elem_lit = pattern_ff[1];

endmodule

// ===== hw/rtl/morse_status_blinker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_status_blinker: Morse code status LED beacon
// Polls a free-running timer and blinks a status code on one LED.
// ----------------------------------------------------------------------------
// Each request is one poll (timer value and status code) and gives one
// response with the LED level after that poll. A request is registered,
// updated combinationally against the frame and flip due times, and the
// LED level lands in an output register: one request per clock while the
// response side does not stall. The configuration port is always ready and
// should be written only while no requests are in flight.
module morse_status_blinker #(
   parameter int TIMER_BITS = msb_pkg::TIMER_BITS_DEF,
   parameter int CODE_COUNT = msb_pkg::CODE_COUNT_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   // [TIMER_BITS-1:0] timer_now, then status_sel (8), zero fill to bytes
   input  logic [((TIMER_BITS + msb_pkg::CODE_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   // [0] led_on, [7:1] zero
   output logic [7:0]                                    rsp_tdata,
   input  logic                                          csr_valid,
   output logic                                          csr_ready,
   input  logic [msb_pkg::CSR_IDX_BITS-1:0]              csr_index,
   input  logic [msb_pkg::CSR_DAT_BITS-1:0]              csr_data
);
   import msb_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   logic [TIMER_BITS-1:0] now_ff;
   logic [CODE_BITS-1:0]  code_ff;
   logic                  out_valid_ff, out_valid_in;
   logic                  led_ff;
   logic                  advance;
   logic                  led_next;
   msb_cfg_type           cfg;
   msb_stat_type          stat;

   assign advance     = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         now_ff  <= req_tdata[TIMER_BITS-1:0];
         code_ff <= req_tdata[TIMER_BITS +: CODE_BITS];
      end
      if (advance) begin
         led_ff <= led_next;
      end
   end

   msb_regs u_regs (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   msb_core #(
      .TIMER_BITS (TIMER_BITS),
      .CODE_COUNT (CODE_COUNT)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .now      (now_ff),
      .code     (code_ff),
      .cfg      (cfg),
      .led_next (led_next),
      .stat     (stat)
   );

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, led_ff};

   a_advance_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("processed request produced no response");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("empty input stage not ready");

   a_lit_on_mark: assert property (@(posedge clock) disable iff (reset)
      stat.lamp |-> stat.elem_lit)
      else $error("LED lit on a non-mark element");

endmodule

// ===== dv/msb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_checker: response checker for the Morse status blinker
// Watches the register, request and response channels. Keeps its own copy of
// the blink timing registers and of the frame and flip state, works out the
// LED level for every accepted request and compares it in order with the
// responses. Reports the failure count and the number of outstanding levels.
// ----------------------------------------------------------------------------
module msb_checker (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   input  logic                                    req_tready,
   // [15:0] timer_now, [23:16] status_sel
   input  logic [((msb_pkg::TIMER_BITS_DEF + msb_pkg::CODE_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   input  logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // [0] led_on, [7:1] zero
   input  logic [7:0]                              rsp_tdata,
   input  logic                                    csr_valid,
   input  logic                                    csr_ready,
   input  logic [msb_pkg::CSR_IDX_BITS-1:0]        csr_index,
   input  logic [msb_pkg::CSR_DAT_BITS-1:0]        csr_data,
   output int                                      fail_count,
   output int                                      pending
);

   import msb_pkg::*;

   localparam int MAX_REPORTS = 10;

   msb_cfg_type               cfg;
   logic [TIMER_BITS_DEF-1:0] frame_due_at;
   logic [TIMER_BITS_DEF-1:0] flip_due_at;
   logic [PATTERN_BITS-1:0]   glyph_left;
   logic                      lit;
   logic                      led_levels_q [$];
   int                        rsp_count;

   function automatic logic [PATTERN_BITS-1:0] morse_glyph(input logic [CODE_BITS-1:0] code);
      case (code)
         8'd0:    return 6'h2E;
         8'd1:    return 6'h02;
         8'd2:    return 6'h0E;
         8'd3:    return 6'h0F;
         8'd4:    return 6'h0B;
         8'd5:    return 6'h0A;
         8'd6:    return 6'h3A;
         8'd7:    return 6'h3F;
         8'd8:    return 6'h2A;
         default: return '0;
      endcase
   endfunction

   // frame step first, then flip step on the same poll
   function automatic logic blink_poll(input logic [TIMER_BITS_DEF-1:0] now,
                                       input logic [CODE_BITS-1:0] code);
      if (now == frame_due_at) begin
         if (code < CODE_COUNT_DEF) begin
            flip_due_at = now;
            glyph_left  = morse_glyph(code);
         end else begin
            glyph_left = '0;
         end
         frame_due_at = now + cfg.frame_ticks;
         lit          = 1'b0;
      end
      if (now == flip_due_at) begin
         if (lit) begin
            flip_due_at = now + cfg.gap_ticks;
            glyph_left  = glyph_left >> ELEM_BITS;
            lit         = 1'b0;
         end else if (glyph_left[ELEM_BITS-1:0] == ELEM_DOT) begin
            flip_due_at = now + cfg.dot_ticks;
            lit         = 1'b1;
         end else if (glyph_left[ELEM_BITS-1:0] == ELEM_DASH) begin
            flip_due_at = now + cfg.dash_ticks;
            lit         = 1'b1;
         end
      end
      return lit;
   endfunction

   always @(posedge clock) begin
      logic expected;
      if (reset) begin
         cfg.dot_ticks   = DOT_RESET;
         cfg.gap_ticks   = GAP_RESET;
         cfg.dash_ticks  = DASH_RESET;
         cfg.frame_ticks = FRAME_RESET;
         frame_due_at    = '0;
         flip_due_at     = '0;
         glyph_left      = '0;
         lit             = 1'b0;
         fail_count      = 0;
         rsp_count       = 0;
         led_levels_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_DOT:   cfg.dot_ticks   = csr_data[TICK_BITS-1:0];
               REG_GAP:   cfg.gap_ticks   = csr_data[TICK_BITS-1:0];
               REG_DASH:  cfg.dash_ticks  = csr_data[TICK_BITS-1:0];
               REG_FRAME: cfg.frame_ticks = csr_data[FRAME_BITS-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            led_levels_q.push_back(blink_poll(req_tdata[TIMER_BITS_DEF-1:0],
                                              req_tdata[TIMER_BITS_DEF +: CODE_BITS]));
         if (rsp_tvalid && rsp_tready) begin
            if (led_levels_q.size() == 0) begin
               if (fail_count < MAX_REPORTS)
                  $display("response %0d: none expected, got rsp_tdata %h",
                           rsp_count, rsp_tdata);
               fail_count++;
            end else begin
               expected = led_levels_q.pop_front();
               if (rsp_tdata !== {7'b0, expected}) begin
                  if (fail_count < MAX_REPORTS)
                     $display("response %0d: led_on expected %0b, got rsp_tdata %h",
                              rsp_count, expected, rsp_tdata);
                  fail_count++;
               end
            end
            rsp_count++;
         end
      end
      pending = led_levels_q.size();
   end

endmodule

// ===== dv/morse_status_blinker_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_status_blinker_tb: testbench top of the Morse status blinker
// Drives polls of a timer that mostly counts up one tick at a time, so that
// frames and element flips are hit, with stray polls mixed in. Runs several
// timing settings, from zero tick counts up to the largest, and a timer
// wrap, under varying sender and receiver idling and one long receiver
// hold-off. The checker beside the block predicts and compares the levels.
// ----------------------------------------------------------------------------
module morse_status_blinker_tb;

   import msb_pkg::*;

   localparam int REQ_W          = ((TIMER_BITS_DEF + CODE_BITS + 7) / 8) * 8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PRESS_CYCLES   = 60;
   localparam int TAIL_CYCLES    = 20;

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_W-1:0]        req_tdata  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [7:0]              rsp_tdata;
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index  = '0;
   logic [CSR_DAT_BITS-1:0] csr_data   = '0;
   int                      fail_count;
   int                      pending;

   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   logic press_req      = 1'b0;
   logic press_done     = 1'b0;
   int   press_left     = 0;
   int   idle_cycles    = 0;

   // timer pacing: where the next frame starts and where the last one began
   logic [15:0] tick;
   logic [15:0] frame_mark;
   logic [15:0] frame_start;
   logic [15:0] cur_frame;
   int          span;
   int          hop_unit;

   morse_status_blinker u_dut (.*);

   msb_checker u_checker (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(negedge clock) begin
      if (press_req && !press_done) begin
         press_done = 1'b1;
         press_left = PRESS_CYCLES;
      end
      if (press_left > 0) begin
         press_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic set_idle(input idle_mode_type mode);
      send_idle_pct  = (mode == IDLE_SEND) ? 67 : (mode == IDLE_BOTH) ? 27 : 0;
      recv_stall_pct = (mode == IDLE_RECV) ? 67 : (mode == IDLE_BOTH) ? 27 : 0;
   endtask

   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DAT_BITS-1:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic program_ticks(input logic [7:0] dot, input logic [7:0] gap,
                                input logic [7:0] dash, input logic [15:0] frame);
      drain();
      write_reg(REG_DOT,   {8'($urandom_range(0, 255)), dot});
      write_reg(REG_GAP,   {8'($urandom_range(0, 255)), gap});
      write_reg(REG_DASH,  {8'($urandom_range(0, 255)), dash});
      write_reg(REG_FRAME, frame);
      write_reg(CSR_IDX_BITS'($urandom_range(int'(REG_FRAME) + 1, 255)), 16'($urandom));
      csr_valid = 1'b0;
      cur_frame = frame;
      span      = 3 * ((dash > dot) ? int'(dash) : int'(dot)) + 2 * int'(gap) + 10;
   endtask

   task automatic poll(input logic [15:0] now, input logic [7:0] code);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {code, now};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      if (now == frame_mark) begin
         frame_start = now;
         frame_mark  = now + cur_frame;
      end
   endtask

   task automatic run_phase(input idle_mode_type mode, input int count);
      logic [15:0] ahead;
      logic [15:0] since;
      logic [7:0]  code;
      int          to_hop;
      set_idle(mode);
      repeat (count) begin
         if ($urandom_range(99) < 4) begin
            // stray poll off the timer sequence
            poll(16'($urandom), 8'($urandom_range(0, 255)));
         end else begin
            ahead  = frame_mark - tick;
            since  = tick - frame_start;
            to_hop = (hop_unit != 0) ? hop_unit - int'(since) % hop_unit : 0;
            if (ahead > 300 && (ahead > cur_frame || since > span))
               tick = frame_mark - 16'($urandom_range(0, 12));
            else if (hop_unit != 0 && to_hop > 16 && ahead > hop_unit + 20)
               tick = tick + 16'(to_hop) - 16'($urandom_range(0, 8));
            else if ($urandom_range(99) >= 15)
               tick = tick + 16'd1;
            code = ($urandom_range(99) < 80) ? 8'($urandom_range(0, 8)) :
                                               8'($urandom_range(9, 255));
            poll(tick, code);
         end
      end
      req_tvalid = 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset       = 1'b0;
      cur_frame   = FRAME_RESET;
      frame_mark  = '0;
      frame_start = '0;
      span        = 3 * int'(DASH_RESET) + 2 * int'(GAP_RESET) + 10;
      hop_unit    = 0;
      set_idle(IDLE_NONE);
      write_reg('1, '1);
      csr_valid = 1'b0;

      // reset timing: dot, dash, gap, idle element, unknown code, wrap of timer bits
      poll(16'd0,     8'd0);
      poll(16'd45,    8'd5);
      poll(16'd105,   8'd0);
      poll(16'd255,   8'd0);
      poll(16'd315,   8'd0);
      poll(16'd360,   8'd0);
      poll(16'd420,   8'd0);
      poll(16'd420,   8'd0);
      poll(16'd750,   8'd200);
      poll(16'd1500,  8'd8);
      poll(16'd1545,  8'd255);
      poll(16'd1605,  8'd128);
      poll(16'd40000, 8'd3);
      poll(16'hFFFF,  8'd9);
      poll(16'd1650,  8'd0);
      poll(16'd2250,  8'd1);
      poll(16'd2250,  8'd2);
      poll(16'd2295,  8'd0);
      req_tvalid = 1'b0;
      tick = 16'd2295;

      program_ticks(8'd2, 8'd3, 8'd5, 16'd40);
      run_phase(IDLE_NONE, 90);
      program_ticks(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                    8'($urandom_range(1, 10)), 16'($urandom_range(20, 80)));
      run_phase(IDLE_SEND, 90);
      program_ticks(8'd1, 8'd1, 8'd1, 16'd1);
      run_phase(IDLE_RECV, 60);
      program_ticks(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                    8'($urandom_range(1, 10)), 16'($urandom_range(20, 80)));
      press_req = 1'b1;
      run_phase(IDLE_BOTH, 90);
      program_ticks(8'd0, 8'd0, 8'd0, 16'd7);
      run_phase(IDLE_NONE, 40);
      program_ticks(8'd0, 8'd0, 8'd0, 16'd0);
      run_phase(IDLE_BOTH, 30);
      // next frame lands just below the top of the timer range
      program_ticks(8'd3, 8'd4, 8'd6, 16'hFFF0 - frame_mark);
      run_phase(IDLE_RECV, 70);
      hop_unit = 255;
      program_ticks(8'd255, 8'd255, 8'd255, 16'hFFFF);
      run_phase(IDLE_SEND, 120);

      while (pending != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
